>>> rtl/uartcrc8_pkg.sv
// ----------------------------------------------------------------------------
// uartcrc8_pkg
// Shared types, constants and the CRC-8 byte update for the register framer.
// ----------------------------------------------------------------------------
package uartcrc8_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RX    = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [6:0] READ_MASK  = 7'h7F;

    // Payload bytes of each frame; the CRC byte follows them.
    localparam logic [2:0] FRAME_LEN_WRITE = 3'd7;
    localparam logic [2:0] FRAME_LEN_READ  = 3'd3;

    // A response is six bytes; the last one carries the CRC.
    localparam int         RESPONSE_BYTES = 6;
    localparam logic [2:0] RESP_LAST_IDX  = 3'(RESPONSE_BYTES - 1);

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  node_address;
        logic [6:0]  register_address;
        logic [31:0] write_value;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] read_value;
        logic        crc_ok;
    } result_t;

    // CRC-8, polynomial 0x07, MSB first, one byte.
    function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> rtl/uart_register_datagram_crc8.sv
// ----------------------------------------------------------------------------
// uart_register_datagram_crc8
// Register-access framer for a single-wire UART link: builds write and read
// request frames with CRC-8 and assembles read responses.
//
//   Channel | Direction | Ports
//   --------+-----------+----------------------------------------------------
//   s_      | in        | s_valid/s_ready, opcode, addresses, value, rx byte
//   m_      | out       | m_valid/m_ready, kind, tx byte, last, value, crc_ok
//
// A write request is sent as eight frame bytes and a read request as four,
// one frame byte per cycle from the frame sequencer while the output is free.
// A request sits in the input register while its bytes go out; the output
// register lets the next request be taken while a result waits on m_ready.
// aresetn is synchronous and clears response collection and the frame index.
// ----------------------------------------------------------------------------
module uart_register_datagram_crc8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_node_address,
    input  logic [6:0]  s_register_address,
    input  logic [31:0] s_write_value,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_tx_byte,
    output logic        m_last,
    output logic [31:0] m_read_value,
    output logic        m_crc_ok
);
    import uartcrc8_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    m_valid_reg;
    result_t out_reg;

    result_t frame_res, resp_res, load_res;
    logic    frame_done, resp_complete;
    logic    out_free, load_out, consume, frame_advance;
    logic    rx_fire, clear;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        load_out      = 1'b0;
        consume       = 1'b0;
        frame_advance = 1'b0;
        load_res      = frame_res;
        if (in_valid_reg) begin
            unique case (item_reg.opcode)
                OP_WRITE, OP_READ: begin
                    frame_advance = out_free;
                    load_out      = out_free;
                    consume       = out_free && frame_done;
                end
                OP_RX: begin
                    load_res = resp_res;
                    if (resp_complete) begin
                        load_out = out_free;
                        consume  = out_free;
                    end else begin
                        consume = 1'b1;
                    end
                end
                default: consume = 1'b1;
            endcase
        end
    end

    assign s_ready = !in_valid_reg || consume;
    assign rx_fire = in_valid_reg && (item_reg.opcode == OP_RX) && consume;
    assign clear   = in_valid_reg && (item_reg.opcode == OP_READ) && consume;

    uartcrc8_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item_reg),
        .advance (frame_advance),
        .res     (frame_res),
        .done    (frame_done)
    );

    uartcrc8_resp u_resp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rx_fire  (rx_fire),
        .rx_byte  (item_reg.rx_byte),
        .clear    (clear),
        .res      (resp_res),
        .complete (resp_complete)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= load_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.opcode           <= opcode_t'(s_opcode);
            item_reg.node_address     <= s_node_address;
            item_reg.register_address <= s_register_address;
            item_reg.write_value      <= s_write_value;
            item_reg.rx_byte          <= s_rx_byte;
        end
        if (load_out) begin
            out_reg <= load_res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = out_reg.kind;
    assign m_tx_byte    = out_reg.tx_byte;
    assign m_last       = out_reg.last;
    assign m_read_value = out_reg.read_value;
    assign m_crc_ok     = out_reg.crc_ok;

    // A request frame is retired only on the output beat that carries its CRC byte.
    a_frame_ends_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && consume
            && (item_reg.opcode == OP_WRITE || item_reg.opcode == OP_READ))
        |-> (load_out && load_res.last))
        else $error("frame retired without its CRC byte");

    // A read result always closes its request and carries no transmit byte.
    a_read_result_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_READ) |-> (m_last && m_tx_byte == 8'h00))
        else $error("malformed read result");

    // A transmit byte never carries response fields.
    a_tx_result_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_TX) |-> (m_read_value == 32'h0 && !m_crc_ok))
        else $error("transmit byte carries response fields");

    // Nothing is loaded into the output while it still holds an untaken result.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !load_out)
        else $error("output overwritten while stalled");

endmodule

>>> rtl/uartcrc8_frame.sv
// ----------------------------------------------------------------------------
// uartcrc8_frame
// Walks a write or read request frame one byte per step, folding each byte
// into a running CRC and closing the frame with the CRC byte.
// ----------------------------------------------------------------------------
module uartcrc8_frame (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  uartcrc8_pkg::item_t   item,
    input  logic                  advance,
    output uartcrc8_pkg::result_t res,
    output logic                  done
);
    import uartcrc8_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic [7:0] crc_reg, crc_next;
    logic [2:0] frame_len;
    logic [7:0] byte_sel;
    logic       is_crc;

    always_comb begin
        frame_len = (item.opcode == OP_WRITE) ? FRAME_LEN_WRITE : FRAME_LEN_READ;
        unique case (idx_reg)
            3'd0: byte_sel = SYNC_BYTE;
            3'd1: byte_sel = item.node_address;
            3'd2: byte_sel = (item.opcode == OP_WRITE)
                            ? (WRITE_FLAG | {1'b0, item.register_address})
                            : {1'b0, item.register_address & READ_MASK};
            3'd3: byte_sel = item.write_value[7:0];
            3'd4: byte_sel = item.write_value[15:8];
            3'd5: byte_sel = item.write_value[23:16];
            3'd6: byte_sel = item.write_value[31:24];
            default: byte_sel = 8'h00;
        endcase
        is_crc = (idx_reg == frame_len);
        done   = is_crc;

        res.kind       = KIND_TX;
        res.tx_byte    = is_crc ? crc_reg : byte_sel;
        res.last       = is_crc;
        res.read_value = 32'h0;
        res.crc_ok     = 1'b0;
    end

    always_comb begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        if (advance) begin
            if (is_crc) begin
                idx_next = 3'd0;
                crc_next = 8'h00;
            end else begin
                idx_next = idx_reg + 3'd1;
                crc_next = crc8_add(crc_reg, byte_sel);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
            crc_reg <= 8'h00;
        end else begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
        end
    end

endmodule

>>> rtl/uartcrc8_resp.sv
// ----------------------------------------------------------------------------
// uartcrc8_resp
// Collects received response bytes, keeps their running CRC and the
// little-endian value, and forms the read result on the final byte.
// ----------------------------------------------------------------------------
module uartcrc8_resp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rx_fire,
    input  logic [7:0]            rx_byte,
    input  logic                  clear,
    output uartcrc8_pkg::result_t res,
    output logic                  complete
);
    import uartcrc8_pkg::*;

    logic [2:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [31:0] value_reg, value_next;

    always_comb begin
        complete = (count_reg == RESP_LAST_IDX);

        res.kind       = KIND_READ;
        res.tx_byte    = 8'h00;
        res.last       = 1'b1;
        res.read_value = value_reg;
        res.crc_ok     = (rx_byte == crc_reg);
    end

    always_comb begin
        count_next = count_reg;
        crc_next   = crc_reg;
        value_next = value_reg;
        priority if (clear || (rx_fire && complete)) begin
            count_next = 3'd0;
            crc_next   = 8'h00;
            value_next = 32'h0;
        end else if (rx_fire) begin
            count_next = count_reg + 3'd1;
            crc_next   = crc8_add(crc_reg, rx_byte);
            unique case (count_reg)
                3'd1:    value_next[7:0]   = value_reg[7:0]   | rx_byte;
                3'd2:    value_next[15:8]  = value_reg[15:8]  | rx_byte;
                3'd3:    value_next[23:16] = value_reg[23:16] | rx_byte;
                3'd4:    value_next[31:24] = value_reg[31:24] | rx_byte;
                default: value_next = value_reg;
            endcase
        end else begin
            count_next = count_reg;
            crc_next   = crc_reg;
            value_next = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
            crc_reg   <= 8'h00;
            value_reg <= 32'h0;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            value_reg <= value_next;
        end
    end

endmodule

>>> tb/tb_uart_register_datagram_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_register_datagram_crc8
// Self-checking bench for the UART register framer. A directed table covers
// opcode extremes, the ignored opcode, writes during response collection and
// read restarts. Random write/read/response sequences follow under three
// flow-control mixes. Every accepted request is run through a local model of
// the framer and each output beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_uart_register_datagram_crc8;
    import uartcrc8_pkg::*;

    typedef struct {
        opcode_t     op;
        logic [7:0]  node;
        logic [6:0]  reg_addr;
        logic [31:0] value;
        logic [7:0]  rx;
        bit          typed;
        result_t     want;
    } request_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = OP_NONE;
    logic [7:0]  s_node_address = 8'h00;
    logic [6:0]  s_register_address = 7'h00;
    logic [31:0] s_write_value = 32'h0;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [7:0]  m_tx_byte;
    logic        m_last;
    logic [31:0] m_read_value;
    logic        m_crc_ok;

    // Typed-in expectation travelling with the request on the input port.
    bit          cur_typed = 1'b0;
    result_t     cur_want = '0;

    int          send_idle_pct = 27;
    int          recv_stall_pct = 59;
    int          error_count = 0;

    // Local copy of the response-collection state.
    logic [2:0]  rsp_count = '0;
    logic [7:0]  rsp_crc = '0;
    logic [31:0] rsp_value = '0;

    result_t     pending_results[$];
    request_row_t directed_rows[$];

    uart_register_datagram_crc8 dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_node_address     (s_node_address),
        .s_register_address (s_register_address),
        .s_write_value      (s_write_value),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_tx_byte          (m_tx_byte),
        .m_last             (m_last),
        .m_read_value       (m_read_value),
        .m_crc_ok           (m_crc_ok)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic request_row_t make_row(input opcode_t op, input logic [7:0] node,
                                              input logic [6:0] reg_addr,
                                              input logic [31:0] value, input logic [7:0] rx,
                                              input bit typed, input result_t want);
        request_row_t row;
        row.op = op;
        row.node = node;
        row.reg_addr = reg_addr;
        row.value = value;
        row.rx = rx;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    // Queue the frame bytes followed by their CRC; last marks the CRC beat.
    task automatic push_frame(input logic [7:0] frame [7], input int n);
        logic [7:0] crc;
        result_t    beat;
        crc = 8'h00;
        for (int k = 0; k < n; k++) begin
            crc = crc8_byte(crc, frame[k]);
        end
        for (int k = 0; k <= n; k++) begin
            beat = '0;
            beat.kind = KIND_TX;
            beat.tx_byte = (k < n) ? frame[k] : crc;
            beat.last = (k == n);
            pending_results.push_back(beat);
        end
    endtask

    task automatic model_request(input opcode_t op, input logic [7:0] node,
                                 input logic [6:0] reg_addr, input logic [31:0] value,
                                 input logic [7:0] rx);
        logic [7:0] frame [7];
        result_t    beat;
        frame = '{default: 8'h00};
        case (op)
            OP_WRITE: begin
                frame[0] = SYNC_BYTE;
                frame[1] = node;
                frame[2] = {1'b0, reg_addr} | WRITE_FLAG;
                frame[3] = value[7:0];
                frame[4] = value[15:8];
                frame[5] = value[23:16];
                frame[6] = value[31:24];
                push_frame(frame, 7);
            end
            OP_READ: begin
                frame[0] = SYNC_BYTE;
                frame[1] = node;
                frame[2] = {1'b0, reg_addr & READ_MASK};
                rsp_count = '0;
                rsp_crc = '0;
                rsp_value = '0;
                push_frame(frame, 3);
            end
            OP_RX: begin
                if (rsp_count >= RESP_LAST_IDX) begin
                    beat = '0;
                    beat.kind = KIND_READ;
                    beat.last = 1'b1;
                    beat.read_value = rsp_value;
                    beat.crc_ok = (rx == rsp_crc);
                    pending_results.push_back(beat);
                    rsp_count = '0;
                    rsp_crc = '0;
                    rsp_value = '0;
                end else begin
                    rsp_crc = crc8_byte(rsp_crc, rx);
                    if (rsp_count >= 3'd1 && rsp_count <= 3'd4) begin
                        rsp_value = rsp_value | (32'(rx) << ((rsp_count - 3'd1) * 8));
                    end
                    rsp_count = rsp_count + 3'd1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Requests are modeled at the edge that accepts them; results are checked
    // in the same block so the order of both within one edge is fixed.
    always @(posedge aclk) begin
        int      depth;
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                depth = pending_results.size();
                model_request(opcode_t'(s_opcode), s_node_address, s_register_address,
                              s_write_value, s_rx_byte);
                if (cur_typed) begin
                    while (pending_results.size() > depth) begin
                        void'(pending_results.pop_back());
                    end
                    pending_results.push_back(cur_want);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %b %h %b %h %b",
                             $time, m_kind, m_tx_byte, m_last, m_read_value, m_crc_ok);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_kind));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(m_tx_byte));
                    check_field("last", 32'(want.last), 32'(m_last));
                    check_field("read_value", want.read_value, m_read_value);
                    check_field("crc_ok", 32'(want.crc_ok), 32'(m_crc_ok));
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Entered and left at a falling edge.
    task automatic send_request(input request_row_t row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= row.op;
        s_node_address <= row.node;
        s_register_address <= row.reg_addr;
        s_write_value <= row.value;
        s_rx_byte <= row.rx;
        cur_typed <= row.typed;
        cur_want <= row.want;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_random(input opcode_t op);
        logic [31:0] value;
        logic [7:0]  rx;
        case ($urandom_range(5))
            0: value = 32'h0000_0000;
            1: value = 32'hFFFF_FFFF;
            default: value = $urandom;
        endcase
        rx = 8'($urandom_range(255));
        // Finish a response with the right CRC more often than chance would.
        if (op == OP_RX && rsp_count == RESP_LAST_IDX && $urandom_range(9) < 6) begin
            rx = rsp_crc;
        end
        send_request(make_row(op, 8'($urandom_range(255)), 7'($urandom_range(127)), value,
                              rx, 1'b0, '0));
    endtask

    initial begin
        result_t zero_ok;
        result_t zero_bad;
        int      sent;

        zero_ok = '0;
        zero_ok.kind = KIND_READ;
        zero_ok.last = 1'b1;
        zero_ok.crc_ok = 1'b1;
        zero_bad = zero_ok;
        zero_bad.crc_ok = 1'b0;

        // Six zero bytes straight after reset: value 0 and a matching CRC.
        for (int k = 0; k < 5; k++) begin
            directed_rows.push_back(make_row(OP_RX, 8'h00, 7'h00, 32'h0, 8'h00, 1'b0, '0));
        end
        directed_rows.push_back(make_row(OP_RX, 8'h00, 7'h00, 32'h0, 8'h00, 1'b1, zero_ok));
        directed_rows.push_back(make_row(OP_NONE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF,
                                         1'b0, '0));
        directed_rows.push_back(make_row(OP_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF,
                                         1'b0, '0));
        directed_rows.push_back(make_row(OP_WRITE, 8'h00, 7'h00, 32'h0, 8'h00, 1'b0, '0));
        directed_rows.push_back(make_row(OP_READ, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF,
                                         1'b0, '0));
        directed_rows.push_back(make_row(OP_READ, 8'h00, 7'h00, 32'h0, 8'h00, 1'b0, '0));
        // A write and an ignored request in the middle of a response must not
        // disturb it; the final byte then misses the CRC of five zeros.
        for (int k = 0; k < 5; k++) begin
            directed_rows.push_back(make_row(OP_RX, 8'h00, 7'h00, 32'h0, 8'h00, 1'b0, '0));
        end
        directed_rows.push_back(make_row(OP_WRITE, 8'hA5, 7'h5A, 32'h1234_5678, 8'h00,
                                         1'b0, '0));
        directed_rows.push_back(make_row(OP_NONE, 8'h00, 7'h00, 32'h0, 8'h00, 1'b0, '0));
        directed_rows.push_back(make_row(OP_RX, 8'h00, 7'h00, 32'h0, 8'h01, 1'b1, zero_bad));
        // A read request abandons a partial response.
        directed_rows.push_back(make_row(OP_RX, 8'h00, 7'h00, 32'h0, 8'hFF, 1'b0, '0));
        directed_rows.push_back(make_row(OP_RX, 8'h00, 7'h00, 32'h0, 8'h80, 1'b0, '0));
        directed_rows.push_back(make_row(OP_READ, 8'h01, 7'h40, 32'h0, 8'h00, 1'b0, '0));
        for (int k = 0; k < 6; k++) begin
            directed_rows.push_back(make_row(OP_RX, 8'h00, 7'h00, 32'h0,
                                             8'hFF >> k, 1'b0, '0));
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i]);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 27;
                    recv_stall_pct = 59;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_stall_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < 30) begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                        // Read request and its six response bytes, now and then
                        // interrupted by a write or an ignored request.
                        send_random(OP_READ);
                        sent++;
                        for (int k = 0; k < 6; k++) begin
                            case ($urandom_range(19))
                                0: begin
                                    send_random(OP_WRITE);
                                    sent++;
                                end
                                1: send_random(OP_NONE);
                                default: ;
                            endcase
                            send_random(OP_RX);
                            sent++;
                        end
                    end
                    11, 12, 13, 14: begin
                        send_random(OP_WRITE);
                        sent++;
                    end
                    15, 16: begin
                        send_random(OP_RX);
                        sent++;
                    end
                    17: begin
                        send_random(OP_READ);
                        sent++;
                    end
                    default: send_random(OP_NONE);
                endcase
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> uart_register_datagram_crc8.f
rtl/uartcrc8_pkg.sv
rtl/uartcrc8_frame.sv
rtl/uartcrc8_resp.sv
rtl/uart_register_datagram_crc8.sv
tb/tb_uart_register_datagram_crc8.sv
